[sv/acs_pkg.sv]
// ----------------------------------------------------------------------------
// acs_pkg
// shared types, codes and helper functions of the alarm clock setting block
// ----------------------------------------------------------------------------
package acs_pkg;

    typedef enum logic [2:0] {
        KIND_SAMPLE       = 3'd0,
        KIND_VIEW_TOGGLE  = 3'd1,
        KIND_SET_TOGGLE   = 3'd2,
        KIND_CURSOR_LEFT  = 3'd3,
        KIND_CURSOR_RIGHT = 3'd4,
        KIND_DECREMENT    = 3'd5,
        KIND_INCREMENT    = 3'd6
    } kind_t;

    localparam logic [1:0] VIEW_CLOCK = 2'd0;
    localparam logic [1:0] VIEW_ALARM = 2'd1;
    localparam logic [1:0] VIEW_SET   = 2'd2;

    localparam logic [4:0] VOICE_ALARM = 5'd25;

    localparam logic [4:0] ALARM_HOUR_RESET   = 5'd15;
    localparam logic [5:0] ALARM_MINUTE_RESET = 6'd13;
    localparam logic [5:0] ALARM_SECOND_RESET = 6'd13;

    localparam logic [6:0] TOP_HOUR    = 7'd23;
    localparam logic [6:0] TOP_MINSEC  = 7'd59;
    localparam logic [6:0] TOP_YEAR    = 7'd99;
    localparam logic [6:0] TOP_MONTH   = 7'd12;
    localparam logic [6:0] TOP_DAY     = 7'd31;
    localparam logic [6:0] TOP_WEEKDAY = 7'd7;
    localparam logic [6:0] BOT_WEEKDAY = 7'd1;
    localparam logic [2:0] TOP_CURSOR_ALARM = 3'd3;
    localparam logic [2:0] TOP_CURSOR_SET   = 3'd7;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 56;

    typedef struct packed {
        logic [2:0] kind;
        logic [6:0] rtc_second;
        logic [6:0] rtc_minute;
        logic [5:0] rtc_hour;
        logic [5:0] rtc_day;
        logic [4:0] rtc_month;
        logic [2:0] rtc_weekday;
        logic [7:0] rtc_year;
    } in_item_t;

    typedef struct packed {
        logic       voice_valid;
        logic [4:0] voice_code;
        logic       rtc_write;
        logic [6:0] out_second;
        logic [6:0] out_minute;
        logic [5:0] out_hour;
        logic [5:0] out_day;
        logic [4:0] out_month;
        logic [2:0] out_weekday;
        logic [7:0] out_year;
        logic [1:0] view_mode;
        logic [2:0] cursor;
    } result_t;

    // high nibble times ten plus low nibble
    function automatic logic [7:0] bcd_in(input logic [7:0] v);
        logic [7:0] hi;
        logic [7:0] lo;
        hi = {4'b0, v[7:4]};
        lo = {4'b0, v[3:0]};
        return hi * 8'd10 + lo;
    endfunction

    // divide by ten through reciprocal multiply, exact for values below 128
    function automatic logic [7:0] bcd_out(input logic [6:0] v);
        logic [17:0] prod;
        logic [6:0]  q;
        logic [6:0]  r;
        prod = {11'b0, v} * 18'd205;
        q    = prod[17:11];
        r    = v - q * 7'd10;
        return {q[3:0], r[3:0]};
    endfunction

    // step with wrap between bottom and top
    function automatic logic [6:0] step_val(input logic [6:0] v, input logic [6:0] bottom,
                                            input logic [6:0] top, input logic up);
        logic [6:0] res;
        if (up) begin
            res = (v >= top) ? bottom : v + 7'd1;
        end else begin
            res = (v <= bottom) ? top : v - 7'd1;
        end
        return res;
    endfunction

endpackage

[sv/alarm_clock_setting_controller.sv]
// ----------------------------------------------------------------------------
// alarm_clock_setting_controller
// key and clock-sample driven alarm clock setting controller, stream top level
// ----------------------------------------------------------------------------
// path: an accepted item waits in the input register and moves into the result
//   register when that slot is free or drains; a stalled sink holds it there
// throughput: one item per cycle while the sink is ready, set by the single update
//   pass through acs_core between the input register and the result register
// reset: synchronous active-low aresetn empties both registers and returns the
//   view, cursor, held time, alarm time and chime counter to their reset values
module alarm_clock_setting_controller (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // second[6:0] minute[13:7] hour[19:14] day[25:20] month[30:26]
    // weekday[33:31] year[41:34], zero pad to 48
    input  logic [acs_pkg::IN_DATA_W-1:0]   s_tdata,
    // kind[2:0]
    input  logic [2:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // voice_code[4:0] out_second[11:5] out_minute[18:12] out_hour[24:19]
    // out_day[30:25] out_month[35:31] out_weekday[38:36] out_year[46:39]
    // view_mode[48:47] cursor[51:49], zero pad to 56
    output logic [acs_pkg::OUT_DATA_W-1:0]  m_tdata,
    // voice_valid[0] rtc_write[1]
    output logic [1:0]                      m_tuser
);
    import acs_pkg::*;

    in_item_t item_reg;
    logic     item_valid_reg;
    result_t  res_reg;
    logic     res_valid_reg;
    result_t  res_next;
    in_item_t item_next;
    logic     advance;

    // input item moves into the result register when that slot is free or drains
    assign advance  = item_valid_reg && (!res_valid_reg || m_tready);
    assign s_tready = !item_valid_reg || advance;

    always_comb begin
        item_next.kind        = s_tuser;
        item_next.rtc_second  = s_tdata[6:0];
        item_next.rtc_minute  = s_tdata[13:7];
        item_next.rtc_hour    = s_tdata[19:14];
        item_next.rtc_day     = s_tdata[25:20];
        item_next.rtc_month   = s_tdata[30:26];
        item_next.rtc_weekday = s_tdata[33:31];
        item_next.rtc_year    = s_tdata[41:34];
    end

    acs_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .item    (item_reg),
        .result  (res_next)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_valid_reg <= 1'b0;
        end else if (s_tready) begin
            item_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg <= item_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res_valid_reg <= 1'b0;
        end else if (advance) begin
            res_valid_reg <= 1'b1;
        end else if (m_tready) begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_tvalid = res_valid_reg;
    assign m_tuser  = {res_reg.rtc_write, res_reg.voice_valid};
    assign m_tdata  = {4'b0, res_reg.cursor, res_reg.view_mode, res_reg.out_year,
                       res_reg.out_weekday, res_reg.out_month, res_reg.out_day,
                       res_reg.out_hour, res_reg.out_minute, res_reg.out_second,
                       res_reg.voice_code};

endmodule

[sv/acs_core.sv]
// ----------------------------------------------------------------------------
// acs_core
// view, cursor, held time and alarm state with the per-item update logic
// ----------------------------------------------------------------------------
module acs_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  acs_pkg::in_item_t item,
    output acs_pkg::result_t  result
);
    import acs_pkg::*;

    logic       alarm_view_reg, alarm_view_next;
    logic       time_setting_reg, time_setting_next;
    logic [2:0] field_cursor_reg, field_cursor_next;
    logic [4:0] held_hour_reg, held_hour_next;
    logic [5:0] held_minute_reg, held_minute_next;
    logic [5:0] held_second_reg, held_second_next;
    logic [4:0] held_day_reg, held_day_next;
    logic [3:0] held_month_reg, held_month_next;
    logic [2:0] held_weekday_reg, held_weekday_next;
    logic [6:0] held_year_reg, held_year_next;
    logic [4:0] alarm_hour_reg, alarm_hour_next;
    logic [5:0] alarm_minute_reg, alarm_minute_next;
    logic [5:0] alarm_second_reg, alarm_second_next;
    logic [1:0] chime_count_reg, chime_count_next;

    logic [7:0] dec_second, dec_minute, dec_hour, dec_day, dec_month, dec_weekday, dec_year;
    logic [7:0] enc_second, enc_minute, enc_hour, enc_day, enc_month, enc_year;
    logic [6:0] step_in, step_bot, step_top, step_res;
    logic [6:0] cur_res;
    logic       up;
    logic       in_setting;

    assign dec_second  = bcd_in({1'b0, item.rtc_second});
    assign dec_minute  = bcd_in({1'b0, item.rtc_minute});
    assign dec_hour    = bcd_in({2'b0, item.rtc_hour});
    assign dec_day     = bcd_in({2'b0, item.rtc_day});
    assign dec_month   = bcd_in({3'b0, item.rtc_month});
    assign dec_weekday = bcd_in({5'b0, item.rtc_weekday});
    assign dec_year    = bcd_in(item.rtc_year);

    assign enc_second = bcd_out({1'b0, held_second_reg});
    assign enc_minute = bcd_out({1'b0, held_minute_reg});
    assign enc_hour   = bcd_out({2'b0, held_hour_reg});
    assign enc_day    = bcd_out({2'b0, held_day_reg});
    assign enc_month  = bcd_out({3'b0, held_month_reg});
    assign enc_year   = bcd_out(held_year_reg);

    assign up         = (item.kind == KIND_INCREMENT);
    assign in_setting = alarm_view_reg || time_setting_reg;

    // operand select for the shared field stepper
    always_comb begin
        step_in  = 7'd0;
        step_bot = 7'd0;
        step_top = 7'd0;
        if (alarm_view_reg) begin
            unique case (field_cursor_reg)
                3'd1: begin step_in = {2'b0, alarm_hour_reg};   step_top = TOP_HOUR;   end
                3'd2: begin step_in = {1'b0, alarm_minute_reg}; step_top = TOP_MINSEC; end
                3'd3: begin step_in = {1'b0, alarm_second_reg}; step_top = TOP_MINSEC; end
                default: ;
            endcase
        end else begin
            unique case (field_cursor_reg)
                3'd1: begin step_in = held_year_reg;            step_top = TOP_YEAR;   end
                3'd2: begin step_in = {3'b0, held_month_reg};   step_top = TOP_MONTH;  end
                3'd3: begin step_in = {2'b0, held_day_reg};     step_top = TOP_DAY;    end
                3'd4: begin
                    step_in  = {4'b0, held_weekday_reg};
                    step_bot = BOT_WEEKDAY;
                    step_top = TOP_WEEKDAY;
                end
                3'd5: begin step_in = {2'b0, held_hour_reg};    step_top = TOP_HOUR;   end
                3'd6: begin step_in = {1'b0, held_minute_reg};  step_top = TOP_MINSEC; end
                3'd7: begin step_in = {1'b0, held_second_reg};  step_top = TOP_MINSEC; end
                default: ;
            endcase
        end
    end

    assign step_res = step_val(step_in, step_bot, step_top, up);
    assign cur_res  = step_val({4'b0, field_cursor_reg}, 7'd0,
                               {4'b0, alarm_view_reg ? TOP_CURSOR_ALARM : TOP_CURSOR_SET},
                               item.kind == KIND_CURSOR_RIGHT);

    always_comb begin
        alarm_view_next   = alarm_view_reg;
        time_setting_next = time_setting_reg;
        field_cursor_next = field_cursor_reg;
        held_hour_next    = held_hour_reg;
        held_minute_next  = held_minute_reg;
        held_second_next  = held_second_reg;
        held_day_next     = held_day_reg;
        held_month_next   = held_month_reg;
        held_weekday_next = held_weekday_reg;
        held_year_next    = held_year_reg;
        alarm_hour_next   = alarm_hour_reg;
        alarm_minute_next = alarm_minute_reg;
        alarm_second_next = alarm_second_reg;
        chime_count_next  = chime_count_reg;
        result            = '0;

        unique case (item.kind)
            KIND_SAMPLE: begin
                if (!in_setting) begin
                    held_second_next  = dec_second[5:0];
                    held_minute_next  = dec_minute[5:0];
                    held_hour_next    = dec_hour[4:0];
                    held_day_next     = dec_day[4:0];
                    held_month_next   = dec_month[3:0];
                    held_weekday_next = dec_weekday[2:0];
                    held_year_next    = dec_year[6:0];
                    if (dec_minute[5:0] == 6'd0 && dec_second[5:0] == 6'd0) begin
                        chime_count_next = (chime_count_reg == 2'd2) ? 2'd2
                                         : chime_count_reg + 2'd1;
                    end else begin
                        chime_count_next = 2'd0;
                    end
                    // alarm wins over the chime
                    if (dec_hour[4:0] == alarm_hour_reg && dec_minute[5:0] == alarm_minute_reg
                        && dec_second[5:0] == alarm_second_reg) begin
                        chime_count_next   = 2'd0;
                        result.voice_valid = 1'b1;
                        result.voice_code  = VOICE_ALARM;
                    end else if (chime_count_next == 2'd1) begin
                        result.voice_valid = 1'b1;
                        result.voice_code  = dec_hour[4:0];
                    end
                end
            end
            KIND_VIEW_TOGGLE: begin
                if (!time_setting_reg) begin
                    alarm_view_next   = !alarm_view_reg;
                    field_cursor_next = 3'd0;
                end
            end
            KIND_SET_TOGGLE: begin
                if (!alarm_view_reg) begin
                    if (time_setting_reg) begin
                        result.rtc_write   = 1'b1;
                        result.out_second  = enc_second[6:0];
                        result.out_minute  = enc_minute[6:0];
                        result.out_hour    = enc_hour[5:0];
                        result.out_day     = enc_day[5:0];
                        result.out_month   = enc_month[4:0];
                        result.out_weekday = held_weekday_reg;
                        result.out_year    = enc_year;
                    end
                    time_setting_next = !time_setting_reg;
                    field_cursor_next = 3'd0;
                end
            end
            KIND_CURSOR_LEFT, KIND_CURSOR_RIGHT: begin
                if (in_setting) begin
                    field_cursor_next = cur_res[2:0];
                end
            end
            KIND_DECREMENT, KIND_INCREMENT: begin
                if (alarm_view_reg) begin
                    unique case (field_cursor_reg)
                        3'd1: alarm_hour_next   = step_res[4:0];
                        3'd2: alarm_minute_next = step_res[5:0];
                        3'd3: alarm_second_next = step_res[5:0];
                        default: ;
                    endcase
                end else if (time_setting_reg) begin
                    unique case (field_cursor_reg)
                        3'd1: held_year_next    = step_res;
                        3'd2: held_month_next   = step_res[3:0];
                        3'd3: held_day_next     = step_res[4:0];
                        3'd4: held_weekday_next = step_res[2:0];
                        3'd5: held_hour_next    = step_res[4:0];
                        3'd6: held_minute_next  = step_res[5:0];
                        3'd7: held_second_next  = step_res[5:0];
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase

        result.view_mode = time_setting_next ? VIEW_SET
                         : (alarm_view_next ? VIEW_ALARM : VIEW_CLOCK);
        result.cursor    = field_cursor_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alarm_view_reg   <= 1'b0;
            time_setting_reg <= 1'b0;
            field_cursor_reg <= 3'd0;
            held_hour_reg    <= '0;
            held_minute_reg  <= '0;
            held_second_reg  <= '0;
            held_day_reg     <= '0;
            held_month_reg   <= '0;
            held_weekday_reg <= '0;
            held_year_reg    <= '0;
            alarm_hour_reg   <= ALARM_HOUR_RESET;
            alarm_minute_reg <= ALARM_MINUTE_RESET;
            alarm_second_reg <= ALARM_SECOND_RESET;
            chime_count_reg  <= 2'd0;
        end else if (advance) begin
            alarm_view_reg   <= alarm_view_next;
            time_setting_reg <= time_setting_next;
            field_cursor_reg <= field_cursor_next;
            held_hour_reg    <= held_hour_next;
            held_minute_reg  <= held_minute_next;
            held_second_reg  <= held_second_next;
            held_day_reg     <= held_day_next;
            held_month_reg   <= held_month_next;
            held_weekday_reg <= held_weekday_next;
            held_year_reg    <= held_year_next;
            alarm_hour_reg   <= alarm_hour_next;
            alarm_minute_reg <= alarm_minute_next;
            alarm_second_reg <= alarm_second_next;
            chime_count_reg  <= chime_count_next;
        end
    end

endmodule

[sv/acs_checker.sv]
// ----------------------------------------------------------------------------
// acs_checker
// port-level checks of the alarm clock setting controller
// ----------------------------------------------------------------------------
module acs_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic [acs_pkg::IN_DATA_W-1:0]   s_tdata,
    input logic [2:0]                      s_tuser,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [acs_pkg::OUT_DATA_W-1:0]  m_tdata,
    input logic [1:0]                      m_tuser
);
    import acs_pkg::*;

    // no result right after reset
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // write fields only with a clock write, voice code only with a voice request
    a_quiet_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser[1] || m_tdata[46:5] == '0) && (m_tuser[0] || m_tdata[4:0] == '0))
        else $error("payload set without its flag");

    // a clock write leaves set mode for the clock view with the cursor cleared
    a_write_exit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[1] |-> m_tdata[48:47] == VIEW_CLOCK && m_tdata[51:49] == 3'd0
                                   && !m_tuser[0])
        else $error("clock write outside set exit");

    // announcements only come from samples in the clock view
    a_voice_view: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata[48:47] == VIEW_CLOCK && m_tdata[51:49] == 3'd0)
        else $error("announcement outside clock view");

endmodule

bind alarm_clock_setting_controller acs_checker u_acs_checker (.*);

[verif/tb_alarm_clock_setting_controller.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_alarm_clock_setting_controller
// drives clock samples and key presses into the stream ports of the alarm
// clock setting controller and checks each result item against a local model
// of the views, cursor, held time, alarm time and chime counter
// ----------------------------------------------------------------------------
module tb_alarm_clock_setting_controller;

    import acs_pkg::*;

    localparam int          CLK_HALF_NS     = 10;
    localparam int          RESET_CYCLES    = 8;
    localparam int          RANDOM_ITEMS    = 600;
    localparam int          HOLD_OFF_CYCLES = 60;
    localparam int          HOLD_OFF_AT     = 150;
    localparam int          DRAIN_CYCLES    = 8;
    localparam int          TIMEOUT_NS      = 10_000_000;
    localparam int          MAX_REPORTS     = 10;
    localparam logic [2:0]  KIND_UNUSED     = 3'd7;

    // one row of stimulus; the pin fields, when pinned is set, replace the
    // model's voice, write, view and cursor fields in the expectation
    typedef struct packed {
        logic [2:0]  kind;
        logic [47:0] data;
        logic        pinned;
        logic        pin_voice;
        logic [4:0]  pin_code;
        logic        pin_write;
        logic [1:0]  pin_view;
        logic [2:0]  pin_cursor;
    } stim_row_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata;
    logic [2:0]             s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic [1:0]             m_tuser;

    alarm_clock_setting_controller uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial aclk = 1'b0;
    always #(CLK_HALF_NS) aclk = ~aclk;

    // model state of the controller
    logic       in_alarm_view;
    logic       in_setting;
    logic [2:0] sel_field;
    logic [4:0] hold_hr;
    logic [5:0] hold_min;
    logic [5:0] hold_sec;
    logic [4:0] hold_day;
    logic [3:0] hold_mon;
    logic [2:0] hold_wd;
    logic [6:0] hold_yr;
    logic [4:0] wake_hr;
    logic [5:0] wake_min;
    logic [5:0] wake_sec;
    logic [1:0] chime_run;

    result_t    pending_results[$];
    stim_row_t  dir_table[$];
    int         errors;
    int         results_seen;
    int         burst_left;
    logic [2:0] burst_kind;

    // bcd byte to binary
    function automatic logic [7:0] from_bcd(input logic [7:0] v);
        int tens;
        int units;
        tens  = int'(v[7:4]);
        units = int'(v[3:0]);
        return 8'(tens * 10 + units);
    endfunction

    // binary to bcd byte
    function automatic logic [7:0] bcd_of(input logic [6:0] v);
        int n;
        n = int'(v);
        return 8'((n / 10) * 16 + n % 10);
    endfunction

    function automatic logic [6:0] wrap_step(input logic [6:0] v, input logic [6:0] lo,
                                             input logic [6:0] hi, input logic up);
        if (up)
            return (v < hi) ? 7'(v + 7'd1) : lo;
        return (v > lo) ? 7'(v - 7'd1) : hi;
    endfunction

    function automatic logic [47:0] sample_word(input logic [6:0] sec, input logic [6:0] mnt,
                                                input logic [5:0] hr, input logic [5:0] day,
                                                input logic [4:0] mon, input logic [2:0] wd,
                                                input logic [7:0] yr);
        return {6'b0, yr, wd, mon, day, hr, mnt, sec};
    endfunction

    function automatic stim_row_t row(input logic [2:0] kind, input logic [47:0] data,
                                      input logic pinned, input logic voice,
                                      input logic [4:0] code, input logic wr,
                                      input logic [1:0] view, input logic [2:0] cur);
        return {kind, data, pinned, voice, code, wr, view, cur};
    endfunction

    // mostly short gaps, some long ones
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    task automatic clear_model();
        in_alarm_view = 1'b0;
        in_setting    = 1'b0;
        sel_field     = 3'd0;
        hold_hr  = '0;
        hold_min = '0;
        hold_sec = '0;
        hold_day = '0;
        hold_mon = '0;
        hold_wd  = '0;
        hold_yr  = '0;
        wake_hr   = ALARM_HOUR_RESET;
        wake_min  = ALARM_MINUTE_RESET;
        wake_sec  = ALARM_SECOND_RESET;
        chime_run = 2'd0;
    endtask

    // advance the model by one item and return the result it produces
    task automatic predict_key_or_sample(input logic [2:0] kind, input logic [47:0] d,
                                         output result_t r);
        logic       up;
        logic [6:0] top;
        r  = '0;
        up = (kind == KIND_INCREMENT) || (kind == KIND_CURSOR_RIGHT);
        case (kind)
            KIND_SAMPLE: begin
                // samples only land in the clock view
                if (!in_alarm_view && !in_setting) begin
                    hold_sec = 6'(from_bcd({1'b0, d[6:0]}));
                    hold_min = 6'(from_bcd({1'b0, d[13:7]}));
                    hold_hr  = 5'(from_bcd({2'b0, d[19:14]}));
                    hold_day = 5'(from_bcd({2'b0, d[25:20]}));
                    hold_mon = 4'(from_bcd({3'b0, d[30:26]}));
                    hold_wd  = d[33:31];
                    hold_yr  = 7'(from_bcd(d[41:34]));
                    if (hold_min == 6'd0 && hold_sec == 6'd0) begin
                        if (chime_run < 2'd2)
                            chime_run = chime_run + 2'd1;
                    end else begin
                        chime_run = 2'd0;
                    end
                    // alarm wins over the chime and restarts the chime count
                    if (hold_hr == wake_hr && hold_min == wake_min && hold_sec == wake_sec) begin
                        chime_run     = 2'd0;
                        r.voice_valid = 1'b1;
                        r.voice_code  = VOICE_ALARM;
                    end else if (chime_run == 2'd1) begin
                        r.voice_valid = 1'b1;
                        r.voice_code  = hold_hr;
                    end
                end
            end
            KIND_VIEW_TOGGLE: begin
                if (!in_setting) begin
                    in_alarm_view = ~in_alarm_view;
                    sel_field     = 3'd0;
                end
            end
            KIND_SET_TOGGLE: begin
                if (!in_alarm_view) begin
                    if (in_setting) begin
                        r.rtc_write   = 1'b1;
                        r.out_second  = 7'(bcd_of({1'b0, hold_sec}));
                        r.out_minute  = 7'(bcd_of({1'b0, hold_min}));
                        r.out_hour    = 6'(bcd_of({2'b0, hold_hr}));
                        r.out_day     = 6'(bcd_of({2'b0, hold_day}));
                        r.out_month   = 5'(bcd_of({3'b0, hold_mon}));
                        r.out_weekday = hold_wd;
                        r.out_year    = bcd_of(hold_yr);
                    end
                    in_setting = ~in_setting;
                    sel_field  = 3'd0;
                end
            end
            KIND_CURSOR_LEFT, KIND_CURSOR_RIGHT: begin
                if (in_alarm_view || in_setting) begin
                    top       = in_alarm_view ? {4'b0, TOP_CURSOR_ALARM} : {4'b0, TOP_CURSOR_SET};
                    sel_field = 3'(wrap_step({4'b0, sel_field}, 7'd0, top, up));
                end
            end
            KIND_DECREMENT, KIND_INCREMENT: begin
                if (in_alarm_view) begin
                    case (sel_field)
                        3'd1: wake_hr  = 5'(wrap_step({2'b0, wake_hr}, 7'd0, TOP_HOUR, up));
                        3'd2: wake_min = 6'(wrap_step({1'b0, wake_min}, 7'd0, TOP_MINSEC, up));
                        3'd3: wake_sec = 6'(wrap_step({1'b0, wake_sec}, 7'd0, TOP_MINSEC, up));
                        default: ;
                    endcase
                end else if (in_setting) begin
                    case (sel_field)
                        3'd1: hold_yr  = wrap_step(hold_yr, 7'd0, TOP_YEAR, up);
                        3'd2: hold_mon = 4'(wrap_step({3'b0, hold_mon}, 7'd0, TOP_MONTH, up));
                        3'd3: hold_day = 5'(wrap_step({2'b0, hold_day}, 7'd0, TOP_DAY, up));
                        3'd4: hold_wd  = 3'(wrap_step({4'b0, hold_wd}, BOT_WEEKDAY,
                                                      TOP_WEEKDAY, up));
                        3'd5: hold_hr  = 5'(wrap_step({2'b0, hold_hr}, 7'd0, TOP_HOUR, up));
                        3'd6: hold_min = 6'(wrap_step({1'b0, hold_min}, 7'd0, TOP_MINSEC, up));
                        3'd7: hold_sec = 6'(wrap_step({1'b0, hold_sec}, 7'd0, TOP_MINSEC, up));
                        default: ;
                    endcase
                end
            end
            default: ;
        endcase
        r.view_mode = in_setting ? VIEW_SET : (in_alarm_view ? VIEW_ALARM : VIEW_CLOCK);
        r.cursor    = sel_field;
    endtask

    // offer one item, wait for the handshake, then queue its expected result
    task automatic drive_item(input stim_row_t item, input logic allow_gap, input int idx);
        result_t want;
        int      gap;
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser  = item.kind;
        s_tdata  = item.data;
        do @(posedge aclk); while (!s_tready);
        predict_key_or_sample(item.kind, item.data, want);
        if (item.pinned) begin
            want.voice_valid = item.pin_voice;
            want.voice_code  = item.pin_code;
            want.rtc_write   = item.pin_write;
            want.view_mode   = item.pin_view;
            want.cursor      = item.pin_cursor;
        end
        pending_results.push_back(want);
        // some stretches run back to back
        gap = (allow_gap && (idx % 80) >= 20) ? idle_len() : 0;
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    function automatic logic [47:0] noise_word();
        return {6'b0, 10'($urandom), 32'($urandom)};
    endfunction

    // random date fields around a chosen time
    function automatic logic [47:0] timed_sample(input logic [6:0] hr, input logic [6:0] mnt,
                                                 input logic [6:0] sec);
        return sample_word(7'(bcd_of(sec)), 7'(bcd_of(mnt)), 6'(bcd_of(hr)),
                           6'(bcd_of(7'($urandom_range(1, 31)))),
                           5'(bcd_of(7'($urandom_range(1, 12)))),
                           3'($urandom_range(1, 7)),
                           bcd_of(7'($urandom_range(0, 99))));
    endfunction

    task automatic make_random_item(output stim_row_t item);
        int         r;
        logic [2:0] kind;
        logic [47:0] d;
        d = noise_word();
        if (burst_left > 0) begin
            kind       = burst_kind;
            burst_left = burst_left - 1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 30)      kind = KIND_SAMPLE;
            else if (r < 38) kind = KIND_VIEW_TOGGLE;
            else if (r < 46) kind = KIND_SET_TOGGLE;
            else if (r < 56) kind = KIND_CURSOR_LEFT;
            else if (r < 66) kind = KIND_CURSOR_RIGHT;
            else if (r < 80) kind = KIND_DECREMENT;
            else if (r < 96) kind = KIND_INCREMENT;
            else             kind = KIND_UNUSED;
            // runs of one step key push fields through their wrap points
            if ((kind == KIND_DECREMENT || kind == KIND_INCREMENT) &&
                $urandom_range(0, 3) == 0) begin
                burst_kind = kind;
                burst_left = $urandom_range(3, 40);
            end
        end
        if (kind == KIND_SAMPLE) begin
            r = $urandom_range(0, 99);
            if (r < 35)
                d = timed_sample(7'($urandom_range(0, 23)), 7'd0, 7'd0);
            else if (r < 50)
                d = timed_sample({2'b0, wake_hr}, {1'b0, wake_min}, {1'b0, wake_sec});
            else if (r < 90)
                d = timed_sample(7'($urandom_range(0, 23)), 7'($urandom_range(0, 59)),
                                 7'($urandom_range(0, 59)));
        end
        item = row(kind, d, 1'b0, 1'b0, 5'd0, 1'b0, VIEW_CLOCK, 3'd0);
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            errors = errors + 1;
            if (errors <= MAX_REPORTS)
                $display("result %0d: %s expected %0d, got %0d", results_seen, name, want, got);
        end
    endtask

    // result monitor
    result_t got_res;
    result_t want_res;

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen = results_seen + 1;
            got_res.voice_valid = m_tuser[0];
            got_res.rtc_write   = m_tuser[1];
            got_res.voice_code  = m_tdata[4:0];
            got_res.out_second  = m_tdata[11:5];
            got_res.out_minute  = m_tdata[18:12];
            got_res.out_hour    = m_tdata[24:19];
            got_res.out_day     = m_tdata[30:25];
            got_res.out_month   = m_tdata[35:31];
            got_res.out_weekday = m_tdata[38:36];
            got_res.out_year    = m_tdata[46:39];
            got_res.view_mode   = m_tdata[48:47];
            got_res.cursor      = m_tdata[51:49];
            if (pending_results.size() == 0) begin
                errors = errors + 1;
                if (errors <= MAX_REPORTS)
                    $display("result %0d arrived with nothing expected", results_seen);
            end else begin
                want_res = pending_results.pop_front();
                check_field("voice_valid", want_res.voice_valid, got_res.voice_valid);
                check_field("voice_code", want_res.voice_code, got_res.voice_code);
                check_field("rtc_write", want_res.rtc_write, got_res.rtc_write);
                check_field("out_second", want_res.out_second, got_res.out_second);
                check_field("out_minute", want_res.out_minute, got_res.out_minute);
                check_field("out_hour", want_res.out_hour, got_res.out_hour);
                check_field("out_day", want_res.out_day, got_res.out_day);
                check_field("out_month", want_res.out_month, got_res.out_month);
                check_field("out_weekday", want_res.out_weekday, got_res.out_weekday);
                check_field("out_year", want_res.out_year, got_res.out_year);
                check_field("view_mode", want_res.view_mode, got_res.view_mode);
                check_field("cursor", want_res.cursor, got_res.cursor);
            end
        end
    end

    // result side ready pattern, with one long hold-off so the block backs up
    initial begin : result_sink
        int  rx_cycle;
        int  stall_left;
        int  n;
        bit  held_off;
        m_tready   = 1'b0;
        rx_cycle   = 0;
        stall_left = 0;
        held_off   = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            rx_cycle = rx_cycle + 1;
            if (!held_off && results_seen >= HOLD_OFF_AT) begin
                held_off = 1'b1;
                m_tready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
            end
            if (stall_left > 0) begin
                m_tready   = 1'b0;
                stall_left = stall_left - 1;
            end else if ((rx_cycle % 128) < 32) begin
                m_tready = 1'b1;
            end else begin
                n = idle_len();
                if (n == 0) begin
                    m_tready = 1'b1;
                end else begin
                    m_tready   = 1'b0;
                    stall_left = n - 1;
                end
            end
        end
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        logic [47:0] ones;
        logic [47:0] day_date;
        logic [47:0] odd_values;
        stim_row_t   item;
        int          useful;
        int          idx;

        aresetn      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        errors       = 0;
        results_seen = 0;
        burst_left   = 0;
        burst_kind   = KIND_INCREMENT;
        clear_model();

        ones       = sample_word(7'h7F, 7'h7F, 6'h3F, 6'h3F, 5'h1F, 3'h7, 8'hFF);
        day_date   = sample_word(7'h00, 7'h00, 6'h12, 6'h15, 5'h06, 3'd3, 8'h24);
        // held fields past the top of their ranges, day at its top, weekday below its bottom
        odd_values = sample_word(7'h63, 7'h60, 6'h29, 6'h31, 5'h13, 3'd0, 8'hA9);

        // chime on the first top-of-hour sample only, then alarm, midnight chime
        dir_table.push_back(row(KIND_SAMPLE, day_date, 1'b1, 1'b1, 5'd12, 1'b0,
                                VIEW_CLOCK, 3'd0));
        dir_table.push_back(row(KIND_SAMPLE, day_date, 1'b1, 1'b0, 5'd0, 1'b0,
                                VIEW_CLOCK, 3'd0));
        dir_table.push_back(row(KIND_SAMPLE,
                                sample_word(7'h13, 7'h13, 6'h15, 6'h01, 5'h01, 3'd1, 8'h00),
                                1'b1, 1'b1, VOICE_ALARM, 1'b0, VIEW_CLOCK, 3'd0));
        dir_table.push_back(row(KIND_SAMPLE, sample_word('0, '0, '0, 6'h01, 5'h01, 3'd1, 8'h99),
                                1'b1, 1'b1, 5'd0, 1'b0, VIEW_CLOCK, 3'd0));
        dir_table.push_back(row(KIND_SAMPLE, ones, 1'b0, 1'b0, 5'd0, 1'b0, VIEW_CLOCK, 3'd0));
        dir_table.push_back(row(KIND_UNUSED, ones, 1'b0, 1'b0, 5'd0, 1'b0, VIEW_CLOCK, 3'd0));
        // keys that do nothing in the clock view
        dir_table.push_back(row(KIND_CURSOR_RIGHT, ones, 1'b1, 1'b0, 5'd0, 1'b0,
                                VIEW_CLOCK, 3'd0));
        dir_table.push_back(row(KIND_INCREMENT, '0, 1'b0, 1'b0, 5'd0, 1'b0, VIEW_CLOCK, 3'd0));
        dir_table.push_back(row(KIND_DECREMENT, '0, 1'b0, 1'b0, 5'd0, 1'b0, VIEW_CLOCK, 3'd0));
        // alarm view: set key and samples ignored, cursor wraps both ways
        dir_table.push_back(row(KIND_VIEW_TOGGLE, '0, 1'b1, 1'b0, 5'd0, 1'b0,
                                VIEW_ALARM, 3'd0));
        dir_table.push_back(row(KIND_SET_TOGGLE, '0, 1'b1, 1'b0, 5'd0, 1'b0, VIEW_ALARM, 3'd0));
        dir_table.push_back(row(KIND_SAMPLE,
                                sample_word(7'h13, 7'h13, 6'h15, 6'h01, 5'h01, 3'd1, 8'h00),
                                1'b1, 1'b0, 5'd0, 1'b0, VIEW_ALARM, 3'd0));
        dir_table.push_back(row(KIND_CURSOR_LEFT, '0, 1'b1, 1'b0, 5'd0, 1'b0,
                                VIEW_ALARM, 3'd3));
        dir_table.push_back(row(KIND_INCREMENT, '0, 1'b0, 1'b0, 5'd0, 1'b0, VIEW_CLOCK, 3'd0));
        dir_table.push_back(row(KIND_CURSOR_RIGHT, '0, 1'b1, 1'b0, 5'd0, 1'b0,
                                VIEW_ALARM, 3'd0));
        dir_table.push_back(row(KIND_DECREMENT, '0, 1'b0, 1'b0, 5'd0, 1'b0, VIEW_CLOCK, 3'd0));
        dir_table.push_back(row(KIND_VIEW_TOGGLE, '0, 1'b1, 1'b0, 5'd0, 1'b0,
                                VIEW_CLOCK, 3'd0));
        // load out-of-range held values, then step and write them back
        dir_table.push_back(row(KIND_SAMPLE, odd_values, 1'b0, 1'b0, 5'd0, 1'b0,
                                VIEW_CLOCK, 3'd0));
        dir_table.push_back(row(KIND_SET_TOGGLE, '0, 1'b1, 1'b0, 5'd0, 1'b0, VIEW_SET, 3'd0));
        dir_table.push_back(row(KIND_VIEW_TOGGLE, '0, 1'b1, 1'b0, 5'd0, 1'b0, VIEW_SET, 3'd0));
        dir_table.push_back(row(KIND_CURSOR_LEFT, '0, 1'b1, 1'b0, 5'd0, 1'b0, VIEW_SET, 3'd7));
        dir_table.push_back(row(KIND_INCREMENT, '0, 1'b0, 1'b0, 5'd0, 1'b0, VIEW_CLOCK, 3'd0));
        dir_table.push_back(row(KIND_CURSOR_LEFT, '0, 1'b1, 1'b0, 5'd0, 1'b0, VIEW_SET, 3'd6));
        dir_table.push_back(row(KIND_DECREMENT, '0, 1'b0, 1'b0, 5'd0, 1'b0, VIEW_CLOCK, 3'd0));
        dir_table.push_back(row(KIND_SET_TOGGLE, '0, 1'b1, 1'b0, 5'd0, 1'b1,
                                VIEW_CLOCK, 3'd0));

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        foreach (dir_table[i])
            drive_item(dir_table[i], 1'b1, i);

        useful = 0;
        idx    = 0;
        while (useful < RANDOM_ITEMS) begin
            make_random_item(item);
            drive_item(item, 1'b1, idx);
            idx = idx + 1;
            if (item.kind != KIND_UNUSED)
                useful = useful + 1;
        end

        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
